// File: sv/fqs_pkg.sv
// Shared types and constants for the queue with content search.
package fqs_pkg;

    // width of one held value
    localparam int DATA_W = 32;

    // request operation codes
    typedef enum logic [1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_CLR  = 2'd2,
        CMD_SRCH = 2'd3
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // controller states
    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic enq;  // cell at the fill level loads the new value
        logic deq;  // every cell takes its neighbor's value, the last cell zero
        logic rot;  // held cells rotate by one toward the head
    } t_cell_ctl;

endpackage

// File: sv/fifo_queue_with_search.sv
// Top level: queue of signed 32-bit values held in a chain of shift cells, with search.
//
// The queue lives in a row of DEPTH cells, the oldest value in cell 0 whenever no search
// is running. Enqueue writes the cell at the fill level, dequeue shifts the whole row one
// cell toward the head, clear resets the fill count; none of these leaves the idle state,
// so a new request can follow as soon as the output register has room. Search rotates the
// held values through cell 0, where the single comparator checks them against the key, so
// a search on a queue of N entries keeps the block busy for N rotation steps, the last of
// which waits while an untaken result still holds the output register (a search on an
// empty queue answers at once); the row is back in its original order when the answer
// appears. Results wait in an output register, so a request is taken while the previous
// result is still waiting as long as that result is being taken in the same cycle or the
// register is empty.
module fifo_queue_with_search #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_cmd,
    input  logic signed [fqs_pkg::DATA_W-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_status,
    output logic signed [fqs_pkg::DATA_W-1:0]   o_head_value,
    output logic [$clog2(DEPTH+1)-1:0]          o_position,
    output logic [$clog2(DEPTH+1)-1:0]          o_count
);
    import fqs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] L_FULL = CNT_W'(DEPTH);

    // control state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_step;
    logic [CNT_W-1:0] r_pos;
    logic [DATA_W-1:0] r_key;
    logic              r_out_valid;

    // result register
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_head_out, n_head_out;
    logic [CNT_W-1:0]  r_pos_out, n_pos_out;
    logic [CNT_W-1:0]  r_cnt_out;

    // datapath
    logic [DATA_W-1:0] w_data [DEPTH];
    logic [DATA_W-1:0] w_next [DEPTH];
    t_cell_ctl         w_ctl;
    t_cmd              w_cmd;
    logic              w_in_fire;
    logic              w_out_free;
    logic              w_load;
    logic              w_step;
    logic              w_last;
    logic              w_match;
    logic              w_srch_start;
    logic [CNT_W-1:0]  w_step_inc;
    logic [CNT_W-1:0]  w_pos_final;

    assign w_cmd      = t_cmd'(i_cmd);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // search bookkeeping
    assign w_step_inc   = r_step + CNT_W'(1);
    assign w_last       = (w_step_inc == r_count);
    assign w_match      = (w_data[0] == r_key);
    assign w_step       = (r_state == S_SEARCH) && (!w_last || w_out_free);
    assign w_srch_start = w_in_fire && (w_cmd == CMD_SRCH) && (r_count != '0);
    assign w_pos_final  = (r_pos != '0) ? r_pos : (w_match ? w_step_inc : '0);

    // cell chain
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == DEPTH - 1) begin : g_end
            assign w_next[k] = '0;
        end else begin : g_mid
            assign w_next[k] = w_data[k+1];
        end

        fqs_cell #(
            .CNT_W (CNT_W),
            .IDX   (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_value (i_value),
            .i_head  (w_data[0]),
            .i_next  (w_next[k]),
            .o_data  (w_data[k])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_srch_start) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_step && w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: cell commands, count update and result
    always_comb begin
        w_ctl      = '0;
        w_load     = 1'b0;
        n_count    = r_count;
        n_status   = ST_OK;
        n_head_out = '0;
        n_pos_out  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    w_load = 1'b1;
                    unique case (w_cmd)
                        CMD_ENQ: begin
                            if (r_count == L_FULL) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.enq = 1'b1;
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        CMD_DEQ: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_ctl.deq  = 1'b1;
                                n_head_out = w_data[0];
                                n_count    = r_count - CNT_W'(1);
                            end
                        end
                        CMD_CLR: begin
                            n_count = '0;
                        end
                        CMD_SRCH: begin
                            // empty queue answers now, otherwise start rotating
                            if (r_count == '0) begin
                                n_status = ST_NOTFOUND;
                            end else begin
                                w_load = 1'b0;
                            end
                        end
                        default: n_status = ST_OK;
                    endcase
                end
            end
            S_SEARCH: begin
                if (w_step) begin
                    w_ctl.rot = 1'b1;
                    if (w_last) begin
                        w_load    = 1'b1;
                        n_pos_out = w_pos_final;
                        n_status  = (w_pos_final != '0) ? ST_OK : ST_NOTFOUND;
                    end
                end
            end
            default: w_load = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_srch_start) begin
                r_step <= '0;
                r_pos  <= '0;
            end else if (w_step && !w_last) begin
                r_step <= w_step_inc;
                if ((r_pos == '0) && w_match) begin
                    r_pos <= w_step_inc;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_srch_start) begin
            r_key <= i_value;
        end
        if (w_load) begin
            r_status   <= n_status;
            r_head_out <= n_head_out;
            r_pos_out  <= n_pos_out;
            r_cnt_out  <= n_count;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_head_value = r_head_out;
    assign o_position   = r_pos_out;
    assign o_count      = r_cnt_out;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= L_FULL)
        else $error("fill count above depth");

    a_busy_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> !o_in_ready)
        else $error("request taken during search");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (w_cmd == CMD_ENQ) && (r_count != L_FULL))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("enqueue did not advance count");

    a_search_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |=> $stable(r_count))
        else $error("count changed during search");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_status == ST_EMPTY)) |-> ((r_head_out == '0) && (r_cnt_out == '0)))
        else $error("empty result carries data");

endmodule

// File: sv/fqs_cell.sv
// One storage cell of the queue chain; cell 0 is the head of the queue.
module fqs_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic                      i_clk,
    input  fqs_pkg::t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0]          i_count,
    input  logic [fqs_pkg::DATA_W-1:0] i_value,
    input  logic [fqs_pkg::DATA_W-1:0] i_head,
    input  logic [fqs_pkg::DATA_W-1:0] i_next,
    output logic [fqs_pkg::DATA_W-1:0] o_data
);
    import fqs_pkg::*;

    localparam logic [CNT_W-1:0] L_IDX = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] L_NXT = CNT_W'(IDX + 1);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // select what this cell holds next
    always_comb begin
        n_data = r_data;
        if (i_ctl.enq && (i_count == L_IDX)) begin
            n_data = i_value;
        end else if (i_ctl.deq) begin
            n_data = i_next;
        end else if (i_ctl.rot) begin
            // last held cell wraps the head around; others take the neighbor
            if (i_count == L_NXT) begin
                n_data = i_head;
            end else if (L_NXT < i_count) begin
                n_data = i_next;
            end
        end
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: dv/fifo_queue_with_search_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the queue with content search: directed table, then random requests.
module fifo_queue_with_search_tb;
    import fqs_pkg::*;

    localparam int DEPTH        = 16;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int RAND_BLOCKS  = 15;
    localparam int BLOCK_LEN    = 104;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 500;
    localparam int DIR_ROWS     = 17;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] head_value;
        logic [CNT_W-1:0]         position;
        logic [CNT_W-1:0]         count;
    } t_queue_result;

    // one directed row; reps repeats the request with value, value+1, ...
    typedef struct packed {
        t_cmd              cmd;
        logic [DATA_W-1:0] value;
        logic [7:0]        reps;
        logic              typed;
        t_queue_result     want;
    } t_dir_row;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_ready;
    logic [1:0]               req_cmd;
    logic signed [DATA_W-1:0] req_value;
    logic                     res_valid;
    logic                     res_ready;
    logic [1:0]               res_status;
    logic signed [DATA_W-1:0] res_head_value;
    logic [CNT_W-1:0]         res_position;
    logic [CNT_W-1:0]         res_count;

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int err_count = 0;
    int idle_cycles = 0;

    // predictor state: held values, oldest first
    logic signed [DATA_W-1:0] model_fifo[$];
    t_queue_result            pending_results[$];

    // expected value typed in where it follows directly from the request
    t_dir_row dir_table [DIR_ROWS] = '{
        // dequeue and search right after reset
        '{CMD_DEQ,  32'h0000_0000, 8'd1,  1'b1, '{ST_EMPTY,    32'sd0, 5'd0, 5'd0}},
        '{CMD_SRCH, 32'h0000_0000, 8'd1,  1'b1, '{ST_NOTFOUND, 32'sd0, 5'd0, 5'd0}},
        '{CMD_ENQ,  32'h7fff_ffff, 8'd1,  1'b1, '{ST_OK,       32'sd0, 5'd0, 5'd1}},
        '{CMD_ENQ,  32'h8000_0000, 8'd1,  1'b1, '{ST_OK,       32'sd0, 5'd0, 5'd2}},
        '{CMD_ENQ,  32'hffff_ffff, 8'd1,  1'b0, '{ST_OK,       32'sd0, 5'd0, 5'd0}},
        // duplicate of the head value
        '{CMD_ENQ,  32'h7fff_ffff, 8'd1,  1'b0, '{ST_OK,       32'sd0, 5'd0, 5'd0}},
        '{CMD_SRCH, 32'h7fff_ffff, 8'd1,  1'b0, '{ST_OK,       32'sd0, 5'd0, 5'd0}},
        '{CMD_SRCH, 32'h0000_0000, 8'd1,  1'b0, '{ST_OK,       32'sd0, 5'd0, 5'd0}},
        // fill up to one below full, fill the last cell, then enqueue into a full queue
        '{CMD_ENQ,  32'h0000_1000, 8'd11, 1'b0, '{ST_OK,       32'sd0, 5'd0, 5'd0}},
        '{CMD_ENQ,  32'h5a5a_5a5a, 8'd1,  1'b0, '{ST_OK,       32'sd0, 5'd0, 5'd0}},
        '{CMD_ENQ,  32'h1234_5678, 8'd1,  1'b1, '{ST_FULL,     32'sd0, 5'd0, 5'd16}},
        // match in the last position of a full queue
        '{CMD_SRCH, 32'h5a5a_5a5a, 8'd1,  1'b0, '{ST_OK,       32'sd0, 5'd0, 5'd0}},
        '{CMD_DEQ,  32'hdead_beef, 8'd1,  1'b0, '{ST_OK,       32'sd0, 5'd0, 5'd0}},
        '{CMD_SRCH, 32'h7fff_ffff, 8'd1,  1'b0, '{ST_OK,       32'sd0, 5'd0, 5'd0}},
        '{CMD_CLR,  32'hffff_ffff, 8'd1,  1'b1, '{ST_OK,       32'sd0, 5'd0, 5'd0}},
        '{CMD_DEQ,  32'h0000_0000, 8'd1,  1'b1, '{ST_EMPTY,    32'sd0, 5'd0, 5'd0}},
        '{CMD_SRCH, 32'h7fff_ffff, 8'd1,  1'b1, '{ST_NOTFOUND, 32'sd0, 5'd0, 5'd0}}
    };

    fifo_queue_with_search #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .o_in_ready   (req_ready),
        .i_cmd        (req_cmd),
        .i_value      (req_value),
        .o_out_valid  (res_valid),
        .i_out_ready  (res_ready),
        .o_status     (res_status),
        .o_head_value (res_head_value),
        .o_position   (res_position),
        .o_count      (res_count)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor: apply one request to the held values and return its result
    function automatic t_queue_result queue_model_step(input t_cmd c,
                                                       input logic signed [DATA_W-1:0] v);
        t_queue_result r;
        bit            found;
        r.status     = ST_OK;
        r.head_value = '0;
        r.position   = '0;
        found        = 1'b0;
        case (c)
            CMD_ENQ: begin
                if (model_fifo.size() >= DEPTH) r.status = ST_FULL;
                else model_fifo.push_back(v);
            end
            CMD_DEQ: begin
                if (model_fifo.size() == 0) r.status = ST_EMPTY;
                else r.head_value = model_fifo.pop_front();
            end
            CMD_CLR: begin
                model_fifo.delete();
            end
            default: begin
                // first match counted from the head, 1-based
                for (int k = 0; k < model_fifo.size() && !found; k++) begin
                    if (model_fifo[k] == v) begin
                        r.position = CNT_W'(k + 1);
                        found      = 1'b1;
                    end
                end
                if (!found) r.status = ST_NOTFOUND;
            end
        endcase
        r.count = CNT_W'(model_fifo.size());
        return r;
    endfunction

    // random data: extremes, a small pool for duplicates, or any 32-bit value
    function automatic logic [DATA_W-1:0] pick_value();
        int                sel;
        logic [DATA_W-1:0] v;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 3))
                0:       v = 32'h7fff_ffff;
                1:       v = 32'h8000_0000;
                2:       v = 32'h0000_0000;
                default: v = 32'hffff_ffff;
            endcase
        end else if (sel <= 2) begin
            v = $urandom_range(0, 7);
        end else begin
            v = $urandom();
        end
        return v;
    endfunction

    // drive one request after a random gap and log its expected result on accept
    task automatic send_request(input t_cmd c, input logic [DATA_W-1:0] v, input bit typed,
                                input t_queue_result want);
        int            gap;
        t_queue_result predicted;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_cmd   <= c;
        req_value <= v;
        do @(posedge clk); while (!req_ready);
        predicted = queue_model_step(c, v);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // hold off new requests until every outstanding result has come back
    task automatic wait_results_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic report_field(input string name, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // stimulus
    initial begin
        int                enq_lim;
        int                deq_lim;
        int                r;
        t_cmd              c;
        logic [DATA_W-1:0] v;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_cmd   = CMD_ENQ;
        req_value = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_table[i]) begin
            for (int k = 0; k < dir_table[i].reps; k++) begin
                send_request(dir_table[i].cmd, dir_table[i].value + k, dir_table[i].typed,
                             dir_table[i].want);
            end
        end
        wait_results_drained();

        // blocks alternate between filling, draining and balanced traffic
        for (int b = 0; b < RAND_BLOCKS; b++) begin
            tx_idle = ($urandom_range(0, 9) < 7);
            rx_idle = ($urandom_range(0, 9) < 7);
            if (b % 4 == 3) wait_results_drained();
            case (b % 3)
                0:       begin enq_lim = 60; deq_lim = 75; end
                1:       begin enq_lim = 25; deq_lim = 65; end
                default: begin enq_lim = 42; deq_lim = 70; end
            endcase
            for (int n = 0; n < BLOCK_LEN; n++) begin
                r = $urandom_range(0, 99);
                if (r < enq_lim)      c = CMD_ENQ;
                else if (r < deq_lim) c = CMD_DEQ;
                else if (r < 97)      c = CMD_SRCH;
                else                  c = CMD_CLR;
                v = pick_value();
                // search keys mostly taken from what is held
                if (c == CMD_SRCH && model_fifo.size() != 0 && $urandom_range(0, 9) < 6)
                    v = model_fifo[$urandom_range(0, model_fifo.size() - 1)];
                send_request(c, v, 1'b0, '0);
            end
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result side: random stall before taking each result
    initial begin
        int stall;
        res_ready = 1'b0;
        forever begin
            @(negedge clk);
            stall = rx_idle ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        t_queue_result want;
        if (rst_n && res_valid && res_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual status %0d count %0d",
                         $time, res_status, res_count);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("status", DATA_W'(want.status), DATA_W'(res_status));
                report_field("head_value", want.head_value, res_head_value);
                report_field("position", DATA_W'(want.position), DATA_W'(res_position));
                report_field("count", DATA_W'(want.count), DATA_W'(res_count));
            end
        end
    end

    // watchdog: too long without any handshake on either side
    always @(posedge clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

// File: files.f
sv/fqs_pkg.sv
sv/fqs_cell.sv
sv/fifo_queue_with_search.sv
dv/fifo_queue_with_search_tb.sv
